/* rtl/core/avc_pkg.sv */
// Shared types and constants for the audio source and volume controller.
// No dependencies; imported by avc_decode and the core top level.
package avc_pkg;

  // Number of selectable sources and the width of a source index
  localparam int SOURCE_COUNT = 8;
  localparam int SRC_W        = $clog2(SOURCE_COUNT);
  localparam logic [SRC_W-1:0] SRC_LAST = SRC_W'(SOURCE_COUNT - 1);

  // Volume codes
  localparam logic [7:0] VOL_DEFAULT = 8'd180;
  localparam logic [7:0] VOL_MAX     = 8'd255;
  localparam logic [7:0] VOL_MIN     = 8'd0;

  // Reset values of the accepted RC5 addresses
  localparam logic [4:0] ADDR_A_RESET = 5'h10;
  localparam logic [4:0] ADDR_B_RESET = 5'h14;

  // Configuration register indexes
  localparam logic [1:0] CFG_ADDR_A = 2'd0;
  localparam logic [1:0] CFG_ADDR_B = 2'd1;

  // RC5 commands (low six bits)
  localparam logic [5:0] CMD_SEL_FIRST = 6'd1;
  localparam logic [5:0] CMD_SEL_LAST  = 6'd8;
  localparam logic [5:0] CMD_MUTE      = 6'd13;
  localparam logic [5:0] CMD_VOL_UP    = 6'd16;
  localparam logic [5:0] CMD_VOL_DOWN  = 6'd17;
  localparam logic [5:0] CMD_SRC_PREV  = 6'd26;
  localparam logic [5:0] CMD_SRC_NEXT  = 6'd27;

  // Event kinds carried on the input tuser
  typedef enum logic [1:0] {
    REQ_IR      = 2'd0,
    REQ_ENCODER = 2'd1,
    REQ_MUTE    = 2'd2,
    REQ_SOURCE  = 2'd3
  } req_t;

  // Decoded operation
  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,
    OP_SELECT = 2'd1,
    OP_MUTE   = 2'd2,
    OP_STEP   = 2'd3
  } op_kind_t;

  typedef struct packed {
    op_kind_t         kind;
    logic [SRC_W-1:0] idx;  // target source for OP_SELECT
    logic             up;   // direction for OP_STEP
  } op_t;

endpackage

/* rtl/core/audio_source_volume_controller_core.sv */
// Top level of the audio source and volume controller: input register, state
// update with per-source volume table, and output register. Uses avc_pkg, avc_decode.
//
//   channel  | direction | handshake               | payload
//   ---------+-----------+-------------------------+-------------------------------
//   s_axis   | in        | s_axis_tvalid/tready    | tuser event kind, tdata fields
//   m_axis   | out       | m_axis_tvalid/tready    | tdata result fields
//   cfg      | in        | cfg_valid/cfg_ready     | cfg_index, cfg_data
//
// One item per cycle sustained while the output is not stalled; an accepted item
// passes from the input register through the state update into the output register.
// The single state read-modify-write per item sets the rate.
// Reset clears the state to the default volume on every source, source 0, unmuted.
// A stalled output holds its result; one more item waits in the input register.
// Configuration writes are always ready and take effect at once.
module audio_source_volume_controller_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // ir_is_rc5, ir_address[4:0], ir_command[6:0],
                                     // encoder_up, zero fill
  input  logic [1:0]  s_axis_tuser,  // req_type[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // action_taken, gain_write, gain_code[7:0],
                                     // relay_change, selected_source[2:0],
                                     // volume_now[7:0], muted_now, zero fill
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data
);
  import avc_pkg::*;

  // Configuration
  logic [4:0] addr_a;
  logic [4:0] addr_b;

  // Input register
  logic        in_valid;
  logic [13:0] in_data;
  req_t        in_req;
  logic        advance;

  // Controller state
  logic [7:0]       vol_tbl [SOURCE_COUNT];
  logic [SRC_W-1:0] src;
  logic [7:0]       vol;
  logic [7:0]       restore;
  logic             mute;
  logic [SRC_W-1:0] src_next;
  logic [7:0]       vol_next;
  logic [7:0]       restore_next;
  logic             mute_next;
  logic             tbl_we;
  logic [7:0]       tbl_wdata;

  // Result fields
  logic       action_next;
  logic       gain_write_next;
  logic [7:0] gain_next;
  logic       relay_next;
  logic       action_taken;
  logic       gain_write;
  logic [7:0] gain_code;
  logic       relay_change;
  logic [2:0] selected_source;
  logic [7:0] volume_now;
  logic       muted_now;

  op_t        op;
  logic [7:0] tbl_rdata;
  logic [7:0] vol_stepped;

  // Config writes
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      addr_a <= ADDR_A_RESET;
      addr_b <= ADDR_B_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_ADDR_A) addr_a <= cfg_data;
      if (cfg_index == CFG_ADDR_B) addr_b <= cfg_data;
    end
  end

  // Handshake: advance when the output register is free or being drained
  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_data <= s_axis_tdata[13:0];
      in_req  <= req_t'(s_axis_tuser);
    end
  end

  avc_decode u_decode (
    .req_type   (in_req),
    .ir_is_rc5  (in_data[0]),
    .ir_address (in_data[5:1]),
    .ir_command (in_data[12:6]),
    .encoder_up (in_data[13]),
    .addr_a     (addr_a),
    .addr_b     (addr_b),
    .src        (src),
    .op         (op)
  );

  assign tbl_rdata   = vol_tbl[op.idx];
  assign vol_stepped = op.up ? ((vol == VOL_MAX) ? vol : vol + 8'd1)
                             : ((vol == VOL_MIN) ? vol : vol - 8'd1);

  // Apply the operation to the state
  always_comb begin
    src_next        = src;
    vol_next        = vol;
    restore_next    = restore;
    mute_next       = mute;
    tbl_we          = 1'b0;
    tbl_wdata       = restore;
    action_next     = 1'b0;
    gain_write_next = 1'b0;
    gain_next       = 8'd0;
    relay_next      = 1'b0;
    case (op.kind)
      OP_SELECT: begin
        src_next        = op.idx;
        vol_next        = tbl_rdata;
        restore_next    = tbl_rdata;
        relay_next      = 1'b1;
        action_next     = 1'b1;
        gain_write_next = 1'b1;
        gain_next       = mute ? 8'd0 : tbl_rdata;
      end
      OP_MUTE, OP_STEP: begin
        action_next     = 1'b1;
        gain_write_next = 1'b1;
        if (mute) begin
          // unmute: restore volume and save it for this source
          mute_next = 1'b0;
          vol_next  = restore;
          tbl_we    = 1'b1;
          tbl_wdata = restore;
          gain_next = restore;
        end else if (op.kind == OP_MUTE) begin
          restore_next = vol;
          mute_next    = 1'b1;
          gain_next    = 8'd0;
        end else begin
          vol_next  = vol_stepped;
          tbl_we    = 1'b1;
          tbl_wdata = vol_stepped;
          gain_next = vol_stepped;
        end
      end
      default: action_next = 1'b0;
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      src     <= '0;
      vol     <= VOL_DEFAULT;
      restore <= VOL_DEFAULT;
      mute    <= 1'b0;
    end else if (advance) begin
      src     <= src_next;
      vol     <= vol_next;
      restore <= restore_next;
      mute    <= mute_next;
    end
  end

  // Per-source volume table, written at the current source
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SOURCE_COUNT; i++) vol_tbl[i] <= VOL_DEFAULT;
    end else if (advance && tbl_we) begin
      vol_tbl[src] <= tbl_wdata;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      action_taken    <= action_next;
      gain_write      <= gain_write_next;
      gain_code       <= gain_next;
      relay_change    <= relay_next;
      selected_source <= 3'(src_next);
      volume_now      <= vol_next;
      muted_now       <= mute_next;
    end
  end

  assign m_axis_tdata = {1'b0, muted_now, volume_now, selected_source, relay_change,
                         gain_code, gain_write, action_taken};

  // Checks
  a_gain_unmuted: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && gain_write && !muted_now |-> gain_code == volume_now)
    else $error("gain code differs from volume while unmuted");

  a_gain_muted: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && muted_now |-> gain_code == 8'd0)
    else $error("nonzero gain code while muted");

  a_idle_result: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !action_taken |-> !gain_write && !relay_change && gain_code == 8'd0)
    else $error("ignored event reports an action");

  a_relay_gain: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && relay_change |-> gain_write && action_taken)
    else $error("relay change without gain write");

  a_advance_out: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_axis_tvalid && selected_source == 3'($past(src_next)))
    else $error("result lost after advance");

endmodule

/* rtl/core/avc_decode.sv */
// Event decoder: turns one control item into a select, mute toggle, volume step or no operation.
// Depends on avc_pkg for the operation struct and command codes.
module avc_decode (
  input  avc_pkg::req_t             req_type,
  input  logic                      ir_is_rc5,
  input  logic [4:0]                ir_address,
  input  logic [6:0]                ir_command,
  input  logic                      encoder_up,
  input  logic [4:0]                addr_a,
  input  logic [4:0]                addr_b,
  input  logic [avc_pkg::SRC_W-1:0] src,
  output avc_pkg::op_t              op
);
  import avc_pkg::*;

  logic [5:0]       cmd;
  logic [5:0]       sel_raw;
  logic             addr_ok;
  logic [SRC_W-1:0] src_next;
  logic [SRC_W-1:0] src_prev;

  // Wrap the source index both ways
  assign src_next = (src == SRC_LAST) ? '0 : src + SRC_W'(1);
  assign src_prev = (src == '0) ? SRC_LAST : src - SRC_W'(1);

  assign cmd     = ir_command[5:0];
  assign sel_raw = cmd - CMD_SEL_FIRST;
  assign addr_ok = ir_is_rc5 && ((ir_address == addr_a) || (ir_address == addr_b));

  // Pick the operation for this item
  always_comb begin
    op.kind = OP_NONE;
    op.idx  = src;
    op.up   = encoder_up;
    case (req_type)
      REQ_IR: begin
        if (addr_ok) begin
          case (cmd) inside
            [CMD_SEL_FIRST:CMD_SEL_LAST]: begin
              if (sel_raw < 6'(SOURCE_COUNT)) begin
                op.kind = OP_SELECT;
                op.idx  = SRC_W'(sel_raw);
              end
            end
            CMD_MUTE: op.kind = OP_MUTE;
            CMD_VOL_UP: begin
              op.kind = OP_STEP;
              op.up   = 1'b1;
            end
            CMD_VOL_DOWN: begin
              op.kind = OP_STEP;
              op.up   = 1'b0;
            end
            CMD_SRC_PREV: begin
              op.kind = OP_SELECT;
              op.idx  = src_prev;
            end
            CMD_SRC_NEXT: begin
              op.kind = OP_SELECT;
              op.idx  = src_next;
            end
            default: op.kind = OP_NONE;
          endcase
        end
      end
      REQ_ENCODER: op.kind = OP_STEP;
      REQ_MUTE:    op.kind = OP_MUTE;
      REQ_SOURCE: begin
        op.kind = OP_SELECT;
        op.idx  = src_next;
      end
      default: op.kind = OP_NONE;
    endcase
  end

endmodule
